// File: rtl/core/vn2d_pkg.sv
package vn2d_pkg;

   // Field widths
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned NOISE_W  = 25;
   localparam int unsigned CORNER_W = 24;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned WEIGHT_W = CORNER_W + 1;   // 0 .. 2^24 inclusive
   localparam int unsigned HASH_W   = 32;
   localparam int unsigned PROD_W   = 50;             // |diff * weight| < 2^48
   localparam int unsigned ACC_W    = PROD_W + 1;

   // Register stages from accepted beat to output register
   localparam int unsigned PIPE_DEPTH = 8;

   // Hash mixing constants
   localparam logic [HASH_W-1:0] HASH_MUL_X  = 32'h85eb_ca6b;
   localparam logic [HASH_W-1:0] HASH_MUL_Z  = 32'hc2b2_ae35;
   localparam logic [HASH_W-1:0] HASH_MUL_M1 = 32'h7feb_352d;
   localparam logic [HASH_W-1:0] HASH_MUL_M2 = 32'h846c_a68b;

   // 1.0 with 24 fraction bits, as seen by the signed output mapping
   localparam logic [NOISE_W-1:0] NOISE_ONE = 25'h100_0000;

   // Configuration register index (byte address / 4)
   typedef enum logic {
      REG_NOISE_SEED    = 1'b0,
      REG_SIGNED_OUTPUT = 1'b1
   } csr_index_type;

   // Lattice corner values of one sample
   typedef struct packed {
      logic [CORNER_W-1:0] n00;
      logic [CORNER_W-1:0] n10;
      logic [CORNER_W-1:0] n01;
      logic [CORNER_W-1:0] n11;
   } corner_vals_type;

endpackage

// File: rtl/core/vn2d_if.sv
// Sample point channel
interface vn2d_req_if import vn2d_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] z_coord;

   modport source (output valid, output x_coord, output z_coord, input ready);
   modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

// Noise result channel
interface vn2d_rsp_if import vn2d_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

// File: rtl/core/value_noise_2d_core.sv
// Channel   Dir  Beat payload                      Handshake
// req_if    in   x_coord, z_coord (Q.FRAC signed)  valid / ready
// rsp_if    out  noise_value (s25, 24 frac bits)   valid / ready
// csr_*     in   noise_seed @0x0, signed_output @0x4  APB, pready tied high
//
// One beat per cycle sustained. Each sample passes eight register stages (hash
// multiplies, ease multiplies, two blend multiply/round pairs, output register);
// the first loads at the accepting edge, and rsp_if.valid rises when the eighth loads.
// reset is synchronous, active high: clears the stage valid bits and the
// configuration registers. A stalled output register freezes every stage
// together; req_if.ready drops only while the output beat is held or in reset.
module value_noise_2d_core import vn2d_pkg::*; #(
   parameter int unsigned COORD_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   vn2d_req_if.sink    req_if,
   vn2d_rsp_if.source  rsp_if
);

   logic [HASH_W-1:0]     seed_ff, seed_in;
   logic                  signed_ff, signed_in;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                  adv;
   logic                  csr_wr;
   csr_index_type         csr_idx;
   corner_vals_type       corners;
   logic [WEIGHT_W-1:0]   wx, wz;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      seed_in    = seed_ff;
      signed_in  = signed_ff;
      csr_prdata = '0;
      case (csr_idx)
         REG_NOISE_SEED: begin
            csr_prdata = seed_ff;
            if (csr_wr) seed_in = csr_pwdata;
         end
         REG_SIGNED_OUTPUT: begin
            csr_prdata = {31'd0, signed_ff};
            if (csr_wr) signed_in = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         signed_ff <= 1'b0;
      end else begin
         seed_ff   <= seed_in;
         signed_ff <= signed_in;
      end
   end

   // Pipeline advance and valid bits
   assign adv          = ~vld_ff[PIPE_DEPTH-1] | rsp_if.ready;
   assign req_if.ready = adv & ~reset;
   assign vld_in       = {vld_ff[PIPE_DEPTH-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_if.valid = vld_ff[PIPE_DEPTH-1];

   // Corner hashes, stages 1-4
   vn2d_hash #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_hash (
      .clock   (clock),
      .en      (adv),
      .seed    (seed_ff),
      .x_coord (req_if.x_coord),
      .z_coord (req_if.z_coord),
      .corners (corners)
   );

   // Eased weights, stages 1-4
   vn2d_ease #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_ease (
      .clock   (clock),
      .en      (adv),
      .x_coord (req_if.x_coord),
      .z_coord (req_if.z_coord),
      .wx      (wx),
      .wz      (wz)
   );

   // Blend and output register, stages 5-8
   vn2d_blend u_blend (
      .clock       (clock),
      .en          (adv),
      .corners     (corners),
      .wx          (wx),
      .wz          (wz),
      .signed_mode (signed_ff),
      .noise_value (rsp_if.noise_value)
   );

endmodule

// File: rtl/core/vn2d_ease.sv
// Smoothstep weights for both axes, 3t^2 - 2t^3, rounded to Q0.24.
// Four register stages: t*t, times (3 - 2t), rounding, alignment.
module vn2d_ease import vn2d_pkg::*; #(
   parameter int unsigned COORD_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [COORD_W-1:0] x_coord,
   input  logic signed [COORD_W-1:0] z_coord,
   output logic [WEIGHT_W-1:0]       wx,
   output logic [WEIGHT_W-1:0]       wz
);

   localparam int unsigned TT_W = 2 * FRAC_W;
   localparam int unsigned K_W  = FRAC_W + 2;
   localparam int unsigned P_W  = TT_W + K_W;
   localparam logic [K_W-1:0] THREE_Q16 = K_W'(3) << FRAC_W;
   localparam logic [P_W-1:0] HALF_Q24  = P_W'(1) << (CORNER_W - 1);

   logic [FRAC_W-1:0]   t_lane [2];

   logic [FRAC_W-1:0]   t_in   [2];
   logic [FRAC_W-1:0]   t_ff   [2];
   logic [TT_W-1:0]     tt_in  [2];
   logic [TT_W-1:0]     tt_ff  [2];
   logic [P_W-1:0]      p_in   [2];
   logic [P_W-1:0]      p_ff   [2];
   logic [WEIGHT_W-1:0] w_in   [2];
   logic [WEIGHT_W-1:0] w_ff   [2];
   logic [WEIGHT_W-1:0] wd_in  [2];
   logic [WEIGHT_W-1:0] wd_ff  [2];
   logic [P_W-1:0]      p_rnd  [2];
   logic [K_W-1:0]      k_lane [2];

   // Fraction brought to 16 bits: truncate extra bits or pad below
   if (COORD_FRAC_BITS >= FRAC_W) begin : g_trunc
      assign t_lane[0] = x_coord[COORD_FRAC_BITS-1 -: FRAC_W];
      assign t_lane[1] = z_coord[COORD_FRAC_BITS-1 -: FRAC_W];
   end else begin : g_pad
      assign t_lane[0] = {x_coord[COORD_FRAC_BITS-1:0], {(FRAC_W-COORD_FRAC_BITS){1'b0}}};
      assign t_lane[1] = {z_coord[COORD_FRAC_BITS-1:0], {(FRAC_W-COORD_FRAC_BITS){1'b0}}};
   end

   // Lane arithmetic, x in lane 0 and z in lane 1
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         t_in[i]   = t_lane[i];
         tt_in[i]  = TT_W'(t_lane[i] * t_lane[i]);
         k_lane[i] = THREE_Q16 - {1'b0, t_ff[i], 1'b0};
         p_in[i]   = P_W'(tt_ff[i] * k_lane[i]);
         p_rnd[i]  = p_ff[i] + HALF_Q24;
         w_in[i]   = p_rnd[i][CORNER_W +: WEIGHT_W];
         wd_in[i]  = w_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff  <= t_in;
         tt_ff <= tt_in;
         p_ff  <= p_in;
         w_ff  <= w_in;
         wd_ff <= wd_in;
      end
   end

   assign wx = wd_ff[0];
   assign wz = wd_ff[1];

endmodule

// File: rtl/core/vn2d_hash.sv
// Lattice cell and four corner hashes, four register stages:
// axis products, first mix multiply, second mix multiply, final fold.
module vn2d_hash import vn2d_pkg::*; #(
   parameter int unsigned COORD_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [HASH_W-1:0]         seed,
   input  logic signed [COORD_W-1:0] x_coord,
   input  logic signed [COORD_W-1:0] z_coord,
   output corner_vals_type           corners
);

   logic [HASH_W-1:0] x0, x1, z0, z1;

   logic [HASH_W-1:0] px_in [2];
   logic [HASH_W-1:0] px_ff [2];
   logic [HASH_W-1:0] pz_in [2];
   logic [HASH_W-1:0] pz_ff [2];
   logic [HASH_W-1:0] m_in  [4];
   logic [HASH_W-1:0] m_ff  [4];
   logic [HASH_W-1:0] q_in  [4];
   logic [HASH_W-1:0] q_ff  [4];
   corner_vals_type   corners_in;
   corner_vals_type   corners_ff;

   // Floor by arithmetic shift; the far corner is one cell on
   assign x0 = HASH_W'(x_coord >>> COORD_FRAC_BITS);
   assign z0 = HASH_W'(z_coord >>> COORD_FRAC_BITS);
   assign x1 = x0 + HASH_W'(1);
   assign z1 = z0 + HASH_W'(1);

   // Stage 1: per-axis multiplies (shared by the corners)
   always_comb begin
      px_in[0] = HASH_W'(x0 * HASH_MUL_X);
      px_in[1] = HASH_W'(x1 * HASH_MUL_X);
      pz_in[0] = HASH_W'(z0 * HASH_MUL_Z);
      pz_in[1] = HASH_W'(z1 * HASH_MUL_Z);
   end

   // Stage 2: seed, rotate, combine, fold, first multiply.
   // Corner k = 2*j + i uses x lane i and z lane j.
   always_comb begin
      logic [HASH_W-1:0] h0, h1, h2;
      for (int k = 0; k < 4; k++) begin
         h0      = seed ^ px_ff[k % 2];
         h1      = {h0[HASH_W-14:0], h0[HASH_W-1 -: 13]} ^ pz_ff[k / 2];
         h2      = h1 ^ (h1 >> 16);
         m_in[k] = HASH_W'(h2 * HASH_MUL_M1);
      end
   end

   // Stage 3: fold and second multiply
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         q_in[k] = HASH_W'((m_ff[k] ^ (m_ff[k] >> 15)) * HASH_MUL_M2);
      end
   end

   // Stage 4: final fold, keep 24 bits
   always_comb begin
      logic [HASH_W-1:0] f [4];
      for (int k = 0; k < 4; k++) begin
         f[k] = q_ff[k] ^ (q_ff[k] >> 16);
      end
      corners_in.n00 = f[0][CORNER_W-1:0];
      corners_in.n10 = f[1][CORNER_W-1:0];
      corners_in.n01 = f[2][CORNER_W-1:0];
      corners_in.n11 = f[3][CORNER_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff      <= px_in;
         pz_ff      <= pz_in;
         m_ff       <= m_in;
         q_ff       <= q_in;
         corners_ff <= corners_in;
      end
   end

   assign corners = corners_ff;

endmodule

// File: rtl/core/vn2d_blend.sv
// Bilinear blend, x first then z, and output mapping.
// Four register stages: row products, row rounding, column product,
// column rounding into the output register.
module vn2d_blend import vn2d_pkg::*; (
   input  logic                       clock,
   input  logic                       en,
   input  corner_vals_type            corners,
   input  logic [WEIGHT_W-1:0]        wx,
   input  logic [WEIGHT_W-1:0]        wz,
   input  logic                       signed_mode,
   output logic signed [NOISE_W-1:0]  noise_value
);

   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (CORNER_W - 1);

   logic signed [PROD_W-1:0]   prod_in  [2];
   logic signed [PROD_W-1:0]   prod_ff  [2];
   logic [CORNER_W-1:0]        base_in  [2];
   logic [CORNER_W-1:0]        base_ff  [2];
   logic [WEIGHT_W-1:0]        wz1_ff;
   logic [WEIGHT_W-1:0]        wz2_ff;
   logic [CORNER_W-1:0]        row_in   [2];
   logic [CORNER_W-1:0]        row_ff   [2];
   logic signed [PROD_W-1:0]   cprod_in;
   logic signed [PROD_W-1:0]   cprod_ff;
   logic [CORNER_W-1:0]        cbase_ff;
   logic [CORNER_W-1:0]        v_lane;
   logic signed [NOISE_W-1:0]  out_in;
   logic signed [NOISE_W-1:0]  out_ff;

   // (b - a) * w, exact
   function automatic logic signed [PROD_W-1:0] diff_mul(
      input logic [CORNER_W-1:0] a,
      input logic [CORNER_W-1:0] b,
      input logic [WEIGHT_W-1:0] w
   );
      logic signed [CORNER_W:0]   d;
      logic signed [WEIGHT_W:0]   ws;
      d  = $signed({1'b0, b}) - $signed({1'b0, a});
      ws = $signed({1'b0, w});
      return PROD_W'(d * ws);
   endfunction

   // a + p / 2^24, rounded half up; lands between a and b
   function automatic logic [CORNER_W-1:0] round_lerp(
      input logic [CORNER_W-1:0]     a,
      input logic signed [PROD_W-1:0] p
   );
      logic signed [ACC_W-1:0] acc;
      acc = $signed({3'b000, a, {CORNER_W{1'b0}}}) + ACC_W'(p) + HALF_LSB;
      return acc[CORNER_W +: CORNER_W];
   endfunction

   // Stage 5: row products along x
   assign prod_in[0] = diff_mul(corners.n00, corners.n10, wx);
   assign prod_in[1] = diff_mul(corners.n01, corners.n11, wx);
   assign base_in[0] = corners.n00;
   assign base_in[1] = corners.n01;

   // Stage 6: row values
   assign row_in[0] = round_lerp(base_ff[0], prod_ff[0]);
   assign row_in[1] = round_lerp(base_ff[1], prod_ff[1]);

   // Stage 7: product along z
   assign cprod_in = diff_mul(row_ff[0], row_ff[1], wz2_ff);

   // Stage 8: final value, optional 2v - 1 mapping
   assign v_lane = round_lerp(cbase_ff, cprod_ff);
   assign out_in = signed_mode ? $signed({v_lane, 1'b0} - NOISE_ONE)
                               : $signed({1'b0, v_lane});

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         base_ff  <= base_in;
         wz1_ff   <= wz;
         row_ff   <= row_in;
         wz2_ff   <= wz1_ff;
         cprod_ff <= cprod_in;
         cbase_ff <= row_ff[0];
         out_ff   <= out_in;
      end
   end

   assign noise_value = out_ff;

endmodule

// File: dv/value_noise_2d_core_tb.sv
module value_noise_2d_core_tb;
   import vn2d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD      = 8;
   localparam int          COORD_FRAC_BITS = 16;
   localparam int          DRAIN_CYCLES    = 12;   // pipeline is eight stages deep
   localparam int          PHASE_ITEMS     = 100;
   localparam int          HOLD_CYCLES     = 80;
   localparam logic [31:0] MIX_X           = 32'h85eb_ca6b;
   localparam logic [31:0] MIX_Z           = 32'hc2b2_ae35;
   localparam logic [31:0] MIX_M1          = 32'h7feb_352d;
   localparam logic [31:0] MIX_M2          = 32'h846c_a68b;
   localparam logic [24:0] UNIT_Q24        = 25'h100_0000;

   // One row of the directed table: configuration, sample point, and an
   // expected noise value where it is obvious without the predictor
   typedef struct packed {
      logic [31:0] seed;
      logic        signed_mode;
      logic [31:0] x_coord;
      logic [31:0] z_coord;
      logic        known;
      logic [24:0] noise;
   } sample_row_type;

   localparam int N_ROWS = 22;

   sample_row_type directed_rows [N_ROWS] = '{
      // plain mode, zero seed: origin hashes to zero
      '{32'h0000_0000, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, 25'd0},
      '{32'h0000_0000, 1'b0, 32'h0000_8000, 32'h0000_0000, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'h8000_0000, 32'h8000_0000, 1'b0, 25'd0},
      // top cell: the far corner sits beyond the largest lattice index
      '{32'h0000_0000, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'h7FFF_0000, 32'h8000_0000, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'h0001_0000, 32'h0000_0000, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'hFFFF_0000, 32'h0001_8000, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b0, 32'h1234_5678, 32'hEDCB_A987, 1'b0, 25'd0},
      // signed mode, zero seed: origin maps to -1.0
      '{32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, UNIT_Q24},
      '{32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 25'd0},
      '{32'h0000_0000, 1'b1, 32'h0000_4000, 32'h0000_C000, 1'b0, 25'd0},
      '{32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 25'd0},
      '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 25'd0},
      '{32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 25'd0},
      '{32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 25'd0},
      '{32'hFFFF_FFFF, 1'b0, 32'h0000_FFFF, 32'hFFFF_0001, 1'b0, 25'd0},
      '{32'hFFFF_FFFF, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 25'd0},
      '{32'h5A5A_5A5A, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 25'd0},
      '{32'h5A5A_5A5A, 1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 25'd0}
   };

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   vn2d_req_if req_if ();
   vn2d_rsp_if rsp_if ();

   value_noise_2d_core #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   // Predictor's copy of the configuration
   logic [31:0] seed_now;
   logic        mode_now;

   logic [24:0] expected_noise [$];
   int          mismatches;
   int          rsp_count;
   int          rsp_seen;
   int          rsp_gap;
   int          rsp_run;
   bit          rsp_calm;
   int          req_run;
   bit          req_calm;
   bit          rsp_hold;
   bit          hold_request;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Murmur-style mix of one lattice corner; low 24 bits are the corner value
   function automatic logic [23:0] lattice_hash(logic [31:0] cx, logic [31:0] cz,
                                                logic [31:0] seed);
      logic [31:0] h;
      h = seed ^ (cx * MIX_X);
      h = {h[18:0], h[31:19]};
      h = h ^ (cz * MIX_Z);
      h = h ^ (h >> 16);
      h = h * MIX_M1;
      h = h ^ (h >> 15);
      h = h * MIX_M2;
      h = h ^ (h >> 16);
      return h[23:0];
   endfunction

   // Fraction of a coordinate brought to Q0.16
   function automatic logic [15:0] frac_q16(logic [31:0] c);
      logic [31:0] f;
      f = c & ((32'd1 << COORD_FRAC_BITS) - 32'd1);
      if (COORD_FRAC_BITS >= 16) begin
         return 16'(f >> (COORD_FRAC_BITS - 16));
      end
      return 16'(f << (16 - COORD_FRAC_BITS));
   endfunction

   // Smoothstep 3t^2-2t^3, exact in Q0.48 then rounded half up to Q0.24
   function automatic logic [24:0] smooth_weight(logic [15:0] t);
      logic [63:0] p;
      p = 64'(t) * 64'(t) * (64'h3_0000 - 64'(t) * 64'd2);
      return 25'((p + 64'h80_0000) >> 24);
   endfunction

   // a + (b-a)*w, rounded half up to 24 fraction bits
   function automatic logic [23:0] lerp_round(logic [23:0] a, logic [23:0] b,
                                              logic [24:0] w);
      logic signed [63:0] acc;
      acc = ($signed({40'd0, a}) <<< 24)
            + ($signed({40'd0, b}) - $signed({40'd0, a})) * $signed({39'd0, w})
            + 64'sd8388608;
      return acc[47:24];
   endfunction

   function automatic logic [24:0] predict_noise(logic [31:0] xc, logic [31:0] zc);
      logic [31:0] x0;
      logic [31:0] z0;
      logic [24:0] ux;
      logic [24:0] uz;
      logic [23:0] row0;
      logic [23:0] row1;
      logic [23:0] v;
      x0   = 32'($signed(xc) >>> COORD_FRAC_BITS);
      z0   = 32'($signed(zc) >>> COORD_FRAC_BITS);
      ux   = smooth_weight(frac_q16(xc));
      uz   = smooth_weight(frac_q16(zc));
      row0 = lerp_round(lattice_hash(x0, z0, seed_now),
                        lattice_hash(x0 + 32'd1, z0, seed_now), ux);
      row1 = lerp_round(lattice_hash(x0, z0 + 32'd1, seed_now),
                        lattice_hash(x0 + 32'd1, z0 + 32'd1, seed_now), ux);
      v    = lerp_round(row0, row1, uz);
      if (mode_now) begin
         return {v, 1'b0} - UNIT_Q24;
      end
      return {1'b0, v};
   endfunction

   // ---------------------------------------------------------------- helpers

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Idle cycles before the next beat; each run is drawn calm or busy at random
   function automatic int draw_gap(inout int run_left, inout bit calm);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 40);
         calm     = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   // Sample coordinate: full range, near origin, near the lattice extremes,
   // or with a fraction at its edges
   function automatic logic [31:0] rand_coord();
      int          c;
      logic [15:0] cell_hi;
      logic [15:0] frac;
      c = int'($urandom_range(0, 15)) - 8;
      case ($urandom_range(0, 4))
         0: begin
            return {c[15:0], 16'($urandom)};
         end
         1: begin
            case ($urandom_range(0, 3))
               0:       cell_hi = 16'h7FFF;
               1:       cell_hi = 16'h8000;
               2:       cell_hi = 16'h7FFE;
               default: cell_hi = 16'h8001;
            endcase
            return {cell_hi, 16'($urandom)};
         end
         2: begin
            case ($urandom_range(0, 3))
               0:       frac = 16'h0000;
               1:       frac = 16'hFFFF;
               2:       frac = 16'h8000;
               default: frac = 16'h0001;
            endcase
            return {16'($urandom), frac};
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic stop_offering();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_noise.size() != 0) @(posedge clock);
   endtask

   // Registers change only with the pipeline empty; the mode write carries
   // junk in the upper bits, which the block must drop
   task automatic apply_config(logic [31:0] seed, logic mode);
      stop_offering();
      wait_for_results();
      csr_write(REG_NOISE_SEED, seed);
      csr_write(REG_SIGNED_OUTPUT, ($urandom & ~32'd1) | 32'(mode));
      seed_now = seed;
      mode_now = mode;
   endtask

   // Offer one sample point and log its expected noise once accepted
   task automatic send_sample(logic [31:0] xc, logic [31:0] zc, logic [24:0] want);
      int gap;
      gap = draw_gap(req_run, req_calm);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.x_coord <= xc;
      req_if.z_coord <= zc;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      expected_noise.insert(expected_noise.size(), want);
   endtask

   // ---------------------------------------------------------------- result side

   // Receiver back-pressure: random gap per beat, plus the long hold-off
   always @(negedge clock) begin
      if (rsp_count != rsp_seen) begin
         rsp_seen = rsp_count;
         rsp_gap  = draw_gap(rsp_run, rsp_calm);
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !rsp_hold;
      end
   end

   initial begin
      wait (hold_request);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_count++;
         if (expected_noise.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat, noise_value %0d",
                                      rsp_if.noise_value));
         end else if (rsp_if.noise_value !== expected_noise[0]) begin
            report_mismatch($sformatf("noise_value got %0d want %0d",
                                      rsp_if.noise_value,
                                      $signed(expected_noise[0])));
            void'(expected_noise.pop_front());
         end else begin
            void'(expected_noise.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      sample_row_type row;
      logic [31:0]    xc;
      logic [31:0]    zc;
      logic [31:0]    phase_seed;
      clock          = 1'b0;
      reset          = 1'b1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      req_if.valid   = 1'b0;
      req_if.x_coord = '0;
      req_if.z_coord = '0;
      rsp_if.ready   = 1'b0;
      seed_now       = '0;
      mode_now       = 1'b0;
      mismatches     = 0;
      rsp_count      = 0;
      rsp_seen       = 0;
      rsp_gap        = 0;
      rsp_run        = 0;
      rsp_calm       = 1'b0;
      req_run        = 0;
      req_calm       = 1'b0;
      rsp_hold       = 1'b0;
      hold_request   = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; the first rows run on the reset configuration
      for (int i = 0; i < N_ROWS; i++) begin
         row = directed_rows[i];
         if (row.seed != seed_now || row.signed_mode != mode_now) begin
            apply_config(row.seed, row.signed_mode);
         end
         send_sample(row.x_coord, row.z_coord,
                     row.known ? row.noise : predict_noise(row.x_coord, row.z_coord));
      end

      // Random phases, each setting a seed (all ones in phase 2) and an output mode
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            2:       phase_seed = 32'hFFFF_FFFF;
            default: phase_seed = $urandom;
         endcase
         apply_config(phase_seed, phase == 1 || phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            xc = rand_coord();
            zc = rand_coord();
            send_sample(xc, zc, predict_noise(xc, zc));
            // receiver stalls long enough to back up the whole pipeline
            if (phase == 1 && n == 30) begin
               hold_request = 1'b1;
            end
            // sender stops until the pipeline has emptied
            if (phase == 2 && n == 50) begin
               stop_offering();
               wait_for_results();
            end
         end
      end

      stop_offering();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_noise.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
